>>> rtl/cesm_pkg.sv
// Package: shared types, constants and helpers for the coil edge speed block.
package cesm_pkg;

  localparam int MAX_DIM = 1024;
  localparam int DIM_W   = $clog2(MAX_DIM);
  localparam int CNT_W   = DIM_W + 1;

  localparam int WIDTH_W  = 11;
  localparam int THR_W    = 9;
  localparam int DIST_W   = 16;
  localparam int RATE_W   = 8;
  localparam int PIXEL_W  = 8;
  localparam int SPEED_W  = 16;
  localparam int FILL_W   = 10;
  localparam int FRAMES_W = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int MUL_A_W = 24;
  localparam int MUL_B_W = (DIM_W > 10) ? DIM_W : 10;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam int NUM_W  = 33;
  localparam int DEN_W  = 26;
  localparam int DIVD_W = NUM_W + 1;
  localparam int DVS_W  = DEN_W + 1;
  localparam int DCNT_W = $clog2(DIVD_W);

  localparam int KMH_SCALE   = 360;
  localparam int MM_PER_UNIT = 1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH,
    REG_HEIGHT,
    REG_THRESHOLD,
    REG_DISTANCE,
    REG_RATE
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_THR,
    S_TOUCH,
    S_DEN,
    S_MULA,
    S_MULB,
    S_LOAD,
    S_DIV,
    S_OUT
  } seq_state_t;

  typedef struct packed {
    logic [WIDTH_W-1:0] coil_width;
    logic [WIDTH_W-1:0] coil_height;
    logic [THR_W-1:0]   touch_threshold;
    logic [DIST_W-1:0]  gate_distance_mm;
    logic [RATE_W-1:0]  frame_rate;
  } cfg_t;

  typedef struct packed {
    logic [CNT_W-1:0] upper;
    logic [CNT_W-1:0] lower;
  } fill_t;

  typedef struct packed {
    logic               speed_valid;
    logic [SPEED_W-1:0] speed_centi_kmh;
    logic               top_touch;
    logic               bottom_touch;
    logic [FILL_W-1:0]  top_fill;
    logic [FILL_W-1:0]  bottom_fill;
  } res_t;

  function automatic logic [CNT_W-1:0] clamp_dim(logic [WIDTH_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (32'(v) < 2) begin
      r = CNT_W'(2);
    end else if (32'(v) > MAX_DIM) begin
      r = CNT_W'(MAX_DIM);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

  function automatic logic [FILL_W-1:0] fill_out(logic [CNT_W-1:0] c);
    logic [FILL_W-1:0] r;
    if (32'(c) > (2 ** FILL_W) - 1) begin
      r = '1;
    end else begin
      r = FILL_W'(c);
    end
    return r;
  endfunction

endpackage

>>> rtl/cesm_pix_if.sv
// Interface: mask pixel input channel.
interface cesm_pix_if;
  import cesm_pkg::*;
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel;
  modport source(output valid, output pixel, input ready);
  modport sink(input valid, input pixel, output ready);
endinterface

>>> rtl/cesm_res_if.sv
// Interface: per-frame result channel.
interface cesm_res_if;
  import cesm_pkg::*;
  logic               valid;
  logic               ready;
  logic               speed_valid;
  logic [SPEED_W-1:0] speed_centi_kmh;
  logic               top_touch;
  logic               bottom_touch;
  logic [FILL_W-1:0]  top_fill;
  logic [FILL_W-1:0]  bottom_fill;
  modport source(output valid, output speed_valid, output speed_centi_kmh,
                 output top_touch, output bottom_touch, output top_fill,
                 output bottom_fill, input ready);
  modport sink(input valid, input speed_valid, input speed_centi_kmh,
               input top_touch, input bottom_touch, input top_fill,
               input bottom_fill, output ready);
endinterface

>>> rtl/cesm_cfg_if.sv
// Interface: configuration register write channel.
interface cesm_cfg_if;
  import cesm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

>>> rtl/cesm_edge_count.sv
// Raster position tracking and edge row fill counting.
module cesm_edge_count (
  input  logic                         clk,
  input  logic                         rst,
  input  cesm_pkg::cfg_t               cfg,
  input  logic                         accept,
  input  logic [cesm_pkg::PIXEL_W-1:0] pixel,
  output logic                         frame_end,
  output cesm_pkg::fill_t              fill
);
  import cesm_pkg::*;

  logic [DIM_W-1:0] col_pos;
  logic [DIM_W-1:0] row_pos;
  logic [CNT_W-1:0] upper_count;
  logic [CNT_W-1:0] lower_count;
  logic [DIM_W-1:0] w_last;
  logic [DIM_W-1:0] h_last;
  logic             last_col;
  logic             last_row;
  logic             counted;

  always_comb begin
    w_last    = DIM_W'(clamp_dim(cfg.coil_width) - CNT_W'(1));
    h_last    = DIM_W'(clamp_dim(cfg.coil_height) - CNT_W'(1));
    last_col  = col_pos >= w_last;
    last_row  = row_pos >= h_last;
    frame_end = last_col && last_row;
    counted   = (pixel != '0) && (col_pos != '0);
    fill.upper = upper_count;
    fill.lower = lower_count;
    if (counted && row_pos == DIM_W'(1) && 32'(upper_count) < MAX_DIM) begin
      fill.upper = upper_count + CNT_W'(1);
    end
    if (counted && last_row && 32'(lower_count) < MAX_DIM) begin
      fill.lower = lower_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos     <= '0;
      row_pos     <= '0;
      upper_count <= '0;
      lower_count <= '0;
    end else if (accept) begin
      if (!last_col) begin
        col_pos     <= col_pos + DIM_W'(1);
        upper_count <= fill.upper;
        lower_count <= fill.lower;
      end else if (!last_row) begin
        col_pos     <= '0;
        row_pos     <= row_pos + DIM_W'(1);
        upper_count <= fill.upper;
        lower_count <= fill.lower;
      end else begin
        col_pos     <= '0;
        row_pos     <= '0;
        upper_count <= '0;
        lower_count <= '0;
      end
    end
  end

endmodule

>>> rtl/cesm_seq.sv
// Frame-end sequencer: shared multiplier, restoring divider, tracking and result register.
module cesm_seq (
  input  logic            clk,
  input  logic            rst,
  input  cesm_pkg::cfg_t  cfg,
  input  logic            start,
  input  cesm_pkg::fill_t fill,
  output logic            idle,
  output logic            res_valid,
  input  logic            res_ready,
  output cesm_pkg::res_t  res_data
);
  import cesm_pkg::*;

  seq_state_t state;
  seq_state_t state_next;

  logic                tracking;
  logic [FRAMES_W-1:0] transit_frames;

  logic [CNT_W-1:0]    upper_q;
  logic [CNT_W-1:0]    lower_q;
  logic                top_q;
  logic                bot_q;
  logic                meas_q;
  logic                use_div;
  logic [SPEED_W-1:0]  speed_q;

  logic [PROD_W-1:0]   prod;
  logic [DEN_W-1:0]    den;
  logic [DIVD_W-1:0]   quo;
  logic [DVS_W-1:0]    rem;
  logic [DVS_W-1:0]    dvs;
  logic [DCNT_W-1:0]   cnt;

  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic                top_hit;
  logic                bot_hit;
  logic                out_free;
  logic [DVS_W:0]      r_shift;
  logic [DVS_W+1:0]    r_diff;
  logic                r_ge;
  logic [SPEED_W-1:0]  speed_fin;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (start) state_next = S_THR;
      S_THR:   state_next = S_TOUCH;
      S_TOUCH: begin
        if (tracking && top_hit && transit_frames != '0) begin
          state_next = S_DEN;
        end else begin
          state_next = S_OUT;
        end
      end
      S_DEN:   state_next = S_MULA;
      S_MULA:  state_next = S_MULB;
      S_MULB:  state_next = S_LOAD;
      S_LOAD:  state_next = S_DIV;
      S_DIV:   if (cnt == DCNT_W'(DIVD_W - 1)) state_next = S_OUT;
      S_OUT:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    idle     = state == S_IDLE;
    out_free = !res_valid || res_ready;
    mul_a    = '0;
    mul_b    = '0;
    case (state)
      S_THR: begin
        mul_a = MUL_A_W'(cfg.touch_threshold);
        mul_b = MUL_B_W'(clamp_dim(cfg.coil_width) - CNT_W'(1));
      end
      S_DEN: begin
        mul_a = MUL_A_W'(transit_frames);
        mul_b = MUL_B_W'(MM_PER_UNIT);
      end
      S_MULA: begin
        mul_a = MUL_A_W'(cfg.gate_distance_mm);
        mul_b = MUL_B_W'(cfg.frame_rate);
      end
      S_MULB: begin
        mul_a = prod[MUL_A_W-1:0];
        mul_b = MUL_B_W'(KMH_SCALE);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    top_hit   = PROD_W'({upper_q, 8'b0}) >= prod;
    bot_hit   = PROD_W'({lower_q, 8'b0}) >= prod;
    r_shift   = {rem, quo[DIVD_W-1]};
    r_diff    = {1'b0, r_shift} - {2'b0, dvs};
    r_ge      = !r_diff[DVS_W+1];
    speed_fin = speed_q;
    if (use_div) begin
      speed_fin = (quo[DIVD_W-1:SPEED_W] != '0) ? '1 : quo[SPEED_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      tracking       <= 1'b0;
      transit_frames <= '0;
      res_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_TOUCH) begin
        if (bot_hit && !top_hit) begin
          tracking <= 1'b1;
          if (!tracking) begin
            transit_frames <= FRAMES_W'(2);
          end else if (transit_frames != '1) begin
            transit_frames <= transit_frames + FRAMES_W'(1);
          end
        end
        if (tracking && top_hit) begin
          tracking <= 1'b0;
        end
      end
      if (state == S_OUT && out_free) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          upper_q <= fill.upper;
          lower_q <= fill.lower;
        end
      end
      S_THR: prod <= PROD_W'(mul_a * mul_b);
      S_TOUCH: begin
        top_q   <= top_hit;
        bot_q   <= bot_hit;
        meas_q  <= tracking && top_hit;
        use_div <= tracking && top_hit && transit_frames != '0;
        speed_q <= (tracking && top_hit) ? '1 : '0;
      end
      S_DEN: prod <= PROD_W'(mul_a * mul_b);
      S_MULA: begin
        den  <= prod[DEN_W-1:0];
        prod <= PROD_W'(mul_a * mul_b);
      end
      S_MULB: prod <= PROD_W'(mul_a * mul_b);
      S_LOAD: begin
        quo <= DIVD_W'({prod[NUM_W-1:0], 1'b0}) + DIVD_W'(den);
        dvs <= {den, 1'b0};
        rem <= '0;
        cnt <= '0;
      end
      S_DIV: begin
        rem <= r_ge ? r_diff[DVS_W-1:0] : r_shift[DVS_W-1:0];
        quo <= {quo[DIVD_W-2:0], r_ge};
        cnt <= cnt + DCNT_W'(1);
      end
      S_OUT: begin
        if (out_free) begin
          res_data.speed_valid     <= meas_q;
          res_data.speed_centi_kmh <= speed_fin;
          res_data.top_touch       <= top_q;
          res_data.bottom_touch    <= bot_q;
          res_data.top_fill        <= fill_out(upper_q);
          res_data.bottom_fill     <= fill_out(lower_q);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/coil_edge_speed_measure.sv
// Top level: coil edge speed measurement with configuration registers.
// Mask pixels are taken one per clock in raster order while the sequencer is
// idle. On the last pixel of a frame the sequencer runs: a shared multiplier
// forms the threshold product, and when a measurement completes it also forms
// the distance and frame terms, then a restoring divider retires one quotient
// bit per cycle. Pixel ready is low while it runs and while the previous result
// still waits in the output register. There is no clearing pass after reset.
// Configuration writes are always taken.
module coil_edge_speed_measure (
  input logic        clk,
  input logic        rst,
  cesm_cfg_if.sink   cfg,
  cesm_pix_if.sink   pix,
  cesm_res_if.source res
);
  import cesm_pkg::*;

  cfg_t  cfg_q;
  fill_t fill;
  res_t  res_data;
  logic  frame_end;
  logic  idle;
  logic  accept;

  assign cfg.ready = 1'b1;
  assign pix.ready = idle;
  assign accept    = pix.valid && pix.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.coil_width       <= WIDTH_W'(64);
      cfg_q.coil_height      <= WIDTH_W'(64);
      cfg_q.touch_threshold  <= THR_W'(128);
      cfg_q.gate_distance_mm <= DIST_W'(5000);
      cfg_q.frame_rate       <= RATE_W'(25);
    end else if (cfg.valid && cfg.ready) begin
      case (reg_idx_t'(cfg.index))
        REG_WIDTH:     cfg_q.coil_width       <= cfg.data[WIDTH_W-1:0];
        REG_HEIGHT:    cfg_q.coil_height      <= cfg.data[WIDTH_W-1:0];
        REG_THRESHOLD: cfg_q.touch_threshold  <= cfg.data[THR_W-1:0];
        REG_DISTANCE:  cfg_q.gate_distance_mm <= cfg.data[DIST_W-1:0];
        REG_RATE:      cfg_q.frame_rate       <= cfg.data[RATE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  cesm_edge_count u_edge (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_q),
    .accept   (accept),
    .pixel    (pix.pixel),
    .frame_end(frame_end),
    .fill     (fill)
  );

  cesm_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_q),
    .start    (accept && frame_end),
    .fill     (fill),
    .idle     (idle),
    .res_valid(res.valid),
    .res_ready(res.ready),
    .res_data (res_data)
  );

  assign res.speed_valid     = res_data.speed_valid;
  assign res.speed_centi_kmh = res_data.speed_centi_kmh;
  assign res.top_touch       = res_data.top_touch;
  assign res.bottom_touch    = res_data.bottom_touch;
  assign res.top_fill        = res_data.top_fill;
  assign res.bottom_fill     = res_data.bottom_fill;

  a_busy_after_frame: assert property (@(posedge clk) disable iff (rst)
    accept && frame_end |=> !pix.ready)
    else $error("pixel ready high right after a frame-end transfer");

  a_speed_needs_top: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.speed_valid |-> res.top_touch)
    else $error("speed reported without a top touch");

  a_speed_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.speed_valid |-> res.speed_centi_kmh == '0)
    else $error("nonzero speed without a measurement");

endmodule
